// ----- sv/smpq_pkg.sv -----
// Shared types, codes and the ordering function of the stable max priority queue.
package smpq_pkg;

  // Default number of cells in the queue.
  localparam int unsigned DepthDefault = 128;

  // Command codes of an input beat.
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_POP = 1'b1;

  // Status codes of an output beat.
  localparam logic [1:0] STATUS_ADDED  = 2'd0;
  localparam logic [1:0] STATUS_POPPED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  // Input beat payload.
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] priority_req;
    logic        [15:0] file_id;
  } in_t;

  // Output beat payload.
  typedef struct packed {
    logic        [1:0]  status;
    logic        [15:0] out_file_id;
    logic signed [15:0] out_priority;
  } out_t;

  // One stored job.
  typedef struct packed {
    logic signed [15:0] prio;
    logic        [31:0] arrival;
    logic        [15:0] tag;
  } entry_t;

  // Row-wide control, broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic pop;
  } ctrl_t;

  // True when job a must be served before job b: higher priority first,
  // then the earlier arrival under a wrap-aware comparison.
  function automatic logic ahead(input entry_t a, input entry_t b);
    logic [31:0] diff;
    diff = a.arrival - b.arrival;
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end
    return diff[31];
  endfunction

endpackage

// ----- sv/smpq_cell.sv -----
// One cell of the sorted row: holds a job and shifts toward its neighbors.
module smpq_cell (
  input  logic             clk_i,
  input  smpq_pkg::ctrl_t  ctrl_i,
  input  smpq_pkg::entry_t new_i,
  input  logic             occupied_i,
  input  smpq_pkg::entry_t left_i,
  input  logic             left_new_ahead_i,
  input  smpq_pkg::entry_t right_i,
  output smpq_pkg::entry_t entry_o,
  output logic             new_ahead_o
);

  smpq_pkg::entry_t entry_q, entry_d;
  logic             new_ahead;

  // The new job belongs at or before this cell when it beats the stored job
  // or the cell is past the end of the queue.
  assign new_ahead = !occupied_i || smpq_pkg::ahead(new_i, entry_q);

  // A pop shifts every job one cell toward the head; an insert opens a gap
  // at the sorted position and shifts the tail one cell back.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = right_i;
    end else if (ctrl_i.insert && new_ahead) begin
      entry_d = left_new_ahead_i ? left_i : new_i;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o     = entry_q;
  assign new_ahead_o = new_ahead;

endmodule

// ----- sv/stable_max_priority_queue.sv -----
// Top level of the stable max priority queue built as a sorted row of cells.
//
// The queue holds up to DEPTH jobs in a row of cells kept sorted from the
// head: higher priority first, and among equal priorities the earlier
// arrival first. Every input beat (add or pop) is handled once taken, since
// all cells compare the new job against their own in parallel and shift
// toward a neighbor in the same cycle; its single result beat sits in an
// output register from the next cycle on. A new beat is taken whenever that
// register is empty or being drained, so the block sustains one beat per
// cycle while the receiver drains. A pop on an empty queue returns status
// empty, an add to a full queue returns status full and stores nothing.
// Cell contents need no clearing; occupancy, arrival number and valid reset.
module stable_max_priority_queue #(
  parameter int unsigned DEPTH = smpq_pkg::DepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  smpq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output smpq_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic [31:0]      arrival_q, arrival_d;
  logic             out_valid_q, out_valid_d;
  smpq_pkg::out_t   out_data_q, out_data_d;

  logic             fire;
  logic             is_full;
  logic             is_empty;
  smpq_pkg::ctrl_t  ctrl;
  smpq_pkg::entry_t new_entry;

  smpq_pkg::entry_t cell_entry [DEPTH];
  logic             cell_new_ahead [DEPTH];

  // Input side takes a beat while the output register is free or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(DEPTH));
  assign is_empty   = (count_q == '0);

  // Row control for this cycle.
  always_comb begin
    ctrl.insert = fire && (in_data_i.cmd == smpq_pkg::CMD_ADD) && !is_full;
    ctrl.pop    = fire && (in_data_i.cmd == smpq_pkg::CMD_POP) && !is_empty;
  end

  // The job offered to the row on an add.
  always_comb begin
    new_entry.prio    = in_data_i.priority_req;
    new_entry.arrival = arrival_q;
    new_entry.tag     = in_data_i.file_id;
  end

  // The row of cells, head at index zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    smpq_pkg::entry_t left_entry;
    smpq_pkg::entry_t right_entry;
    logic             left_ahead;
    logic             occupied;

    assign occupied = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_ahead = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_ahead = cell_new_ahead[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    smpq_cell u_cell (
      .clk_i            (clk_i),
      .ctrl_i           (ctrl),
      .new_i            (new_entry),
      .occupied_i       (occupied),
      .left_i           (left_entry),
      .left_new_ahead_i (left_ahead),
      .right_i          (right_entry),
      .entry_o          (cell_entry[i]),
      .new_ahead_o      (cell_new_ahead[i])
    );
  end

  // Occupancy and arrival number follow the accepted commands.
  always_comb begin
    count_d   = count_q;
    arrival_d = arrival_q;
    if (ctrl.insert) begin
      count_d   = count_q + CntW'(1);
      arrival_d = arrival_q + 32'd1;
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Result beat for the accepted command.
  always_comb begin
    out_data_d = '0;
    if (in_data_i.cmd == smpq_pkg::CMD_ADD) begin
      out_data_d.status = is_full ? smpq_pkg::STATUS_FULL : smpq_pkg::STATUS_ADDED;
    end else if (is_empty) begin
      out_data_d.status = smpq_pkg::STATUS_EMPTY;
    end else begin
      out_data_d.status       = smpq_pkg::STATUS_POPPED;
      out_data_d.out_file_id  = cell_entry[0].tag;
      out_data_d.out_priority = cell_entry[0].prio;
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      arrival_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      arrival_q   <= arrival_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the stable max priority queue with a heap-based predictor.
module tb_top;

  localparam int unsigned QDEPTH = smpq_pkg::DepthDefault;

  // Receiver drain patterns.
  typedef enum int {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_SPARSE
  } drain_mode_e;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  smpq_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  smpq_pkg::out_t out_data;

  stable_max_priority_queue #(
    .DEPTH(QDEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Free-running clock, period 12.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predicted queue contents, kept as a binary max-heap.
  logic signed [15:0] heap_prio    [QDEPTH];
  logic        [31:0] heap_arrival [QDEPTH];
  logic        [15:0] heap_tag     [QDEPTH];
  int unsigned        heap_count = 0;
  logic        [31:0] next_arrival = '0;

  // Result beats still owed by the block, oldest first.
  smpq_pkg::out_t pending_results[$];

  int error_count = 0;
  int items_sent = 0;
  int added_seen = 0;
  int popped_seen = 0;
  int empty_seen = 0;
  int full_seen = 0;

  // True when slot a leaves the queue before slot b.
  function automatic bit served_before(int unsigned a, int unsigned b);
    logic [31:0] gap;
    gap = heap_arrival[a] - heap_arrival[b];
    if (heap_prio[a] != heap_prio[b]) begin
      return heap_prio[a] > heap_prio[b];
    end
    return gap[31];
  endfunction

  function automatic void exchange_slots(int unsigned a, int unsigned b);
    logic signed [15:0] p;
    logic        [31:0] r;
    logic        [15:0] t;
    p = heap_prio[a];
    r = heap_arrival[a];
    t = heap_tag[a];
    heap_prio[a] = heap_prio[b];
    heap_arrival[a] = heap_arrival[b];
    heap_tag[a] = heap_tag[b];
    heap_prio[b] = p;
    heap_arrival[b] = r;
    heap_tag[b] = t;
  endfunction

  // Applies one accepted job beat to the predicted queue and returns its result.
  function automatic smpq_pkg::out_t apply_job(smpq_pkg::in_t job);
    smpq_pkg::out_t res;
    int unsigned    i;
    int unsigned    parent;
    int unsigned    lft;
    int unsigned    rgt;
    int unsigned    best;
    res = '0;
    if (job.cmd == smpq_pkg::CMD_ADD) begin
      if (heap_count >= QDEPTH) begin
        res.status = smpq_pkg::STATUS_FULL;
        return res;
      end
      heap_prio[heap_count] = job.priority_req;
      heap_arrival[heap_count] = next_arrival;
      heap_tag[heap_count] = job.file_id;
      heap_count++;
      next_arrival = next_arrival + 32'd1;
      // Sift the new job up toward the root.
      i = heap_count - 1;
      while (i > 0) begin
        parent = (i - 1) / 2;
        if (!served_before(i, parent)) break;
        exchange_slots(i, parent);
        i = parent;
      end
      res.status = smpq_pkg::STATUS_ADDED;
    end else if (heap_count == 0) begin
      res.status = smpq_pkg::STATUS_EMPTY;
    end else begin
      res.status = smpq_pkg::STATUS_POPPED;
      res.out_file_id = heap_tag[0];
      res.out_priority = heap_prio[0];
      heap_count--;
      if (heap_count > 0) begin
        // Move the last job to the root and sift it down; the left child wins a tie.
        exchange_slots(0, heap_count);
        i = 0;
        while (1'b1) begin
          lft = 2 * i + 1;
          rgt = lft + 1;
          if (lft >= heap_count) break;
          best = lft;
          if (rgt < heap_count && served_before(rgt, lft)) best = rgt;
          if (!served_before(best, i)) break;
          exchange_slots(best, i);
          i = best;
        end
      end
    end
    return res;
  endfunction

  // Sender burst control.
  int burst_left = 0;
  bit steady_sender = 1'b0;

  // Offers one job beat, waits for its acceptance and records the expected result.
  // Called and returns at a falling edge; valid is left high for the next beat.
  task automatic send_job(input logic cmd, input logic signed [15:0] prio,
                          input logic [15:0] tag);
    smpq_pkg::in_t job;
    int            gap;
    job.cmd = cmd;
    job.priority_req = prio;
    job.file_id = tag;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= job;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_job(job));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic add_job(input logic signed [15:0] prio, input logic [15:0] tag);
    send_job(smpq_pkg::CMD_ADD, prio, tag);
  endtask

  // Pop beats carry random noise in the unused fields.
  task automatic pop_job();
    send_job(smpq_pkg::CMD_POP, 16'($urandom()), 16'($urandom()));
  endtask

  // Narrow priorities give many ties; wide ones cover every bit.
  function automatic logic signed [15:0] pick_priority(bit narrow);
    int v;
    if (narrow) v = $urandom_range(0, 6) - 3;
    else v = $urandom();
    return v[15:0];
  endfunction

  // Long receiver hold-off orders, written by the tests at falling edges.
  int hold_len = 0;
  int hold_orders = 0;

  // Receiver: decides the next ready value at the rising edge, drives it at the falling edge.
  int          hold_served = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  drain_mode_e drain_mode = DRAIN_FREE;
  logic        ready_next = 1'b0;

  always @(posedge clk) begin
    if (hold_orders != hold_served) begin
      hold_served = hold_orders;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      if (mode_left == 0) begin
        drain_mode = drain_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 60);
      end
      mode_left--;
      case (drain_mode)
        DRAIN_FREE: begin
          ready_next = 1'b1;
        end
        DRAIN_RANDOM: begin
          ready_next = $urandom_range(0, 1);
        end
        default: begin
          ready_next = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  always @(negedge clk) begin
    out_ready <= ready_next;
  end

  task automatic note_mismatch(input string field, input int want_v, input int got_v);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
  endtask

  // Checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    smpq_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      case (out_data.status)
        smpq_pkg::STATUS_ADDED:  added_seen++;
        smpq_pkg::STATUS_POPPED: popped_seen++;
        smpq_pkg::STATUS_EMPTY:  empty_seen++;
        default:                 full_seen++;
      endcase
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          note_mismatch("status", want.status, out_data.status);
        if (out_data.out_file_id !== want.out_file_id)
          note_mismatch("out_file_id", want.out_file_id, out_data.out_file_id);
        if (out_data.out_priority !== want.out_priority)
          note_mismatch("out_priority", want.out_priority, out_data.out_priority);
      end
    end
  end

  // Pops on an empty queue right after reset.
  task automatic test_empty_pops();
    pop_job();
    pop_job();
  endtask

  // Extreme priorities and tags, ties at the top and at 5, then a full drain and one more pop.
  task automatic test_extremes_and_ties();
    add_job(-16'sd32768, 16'h0000);
    add_job(16'sd32767, 16'hFFFF);
    add_job(16'sd0, 16'h1234);
    add_job(16'sd5, 16'h0001);
    add_job(16'sd5, 16'h0002);
    add_job(16'sd5, 16'h0003);
    add_job(-16'sd1, 16'h8000);
    add_job(16'sd32767, 16'h7FFF);
    repeat (9) pop_job();
  endtask

  // Fills the queue, tries adds while full, swaps one job, then drains past empty.
  task automatic test_fill_and_overflow();
    while (heap_count < QDEPTH) begin
      add_job(pick_priority($urandom_range(0, 1)), 16'($urandom()));
    end
    add_job(16'sd32767, 16'hFFFF);
    repeat (3) add_job(pick_priority(1'b0), 16'($urandom()));
    pop_job();
    add_job(pick_priority(1'b1), 16'($urandom()));
    add_job(pick_priority(1'b1), 16'($urandom()));
    while (heap_count > 0) pop_job();
    pop_job();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering beats.
  task automatic test_backpressure();
    steady_sender = 1'b1;
    hold_len = 150;
    hold_orders++;
    repeat (25) begin
      if ($urandom_range(0, 3) == 0) pop_job();
      else add_job(pick_priority(1'b1), 16'($urandom()));
    end
    steady_sender = 1'b0;
  endtask

  // Phases of random add and pop mixes with varying tie density and sender gaps.
  task automatic test_random_mix();
    int add_pct;
    bit narrow;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0:       add_pct = 25;
        1:       add_pct = 50;
        2:       add_pct = 75;
        default: add_pct = 90;
      endcase
      narrow = $urandom_range(0, 1);
      steady_sender = ($urandom_range(0, 3) == 0);
      repeat (42) begin
        if ($urandom_range(1, 100) <= add_pct) add_job(pick_priority(narrow), 16'($urandom()));
        else pop_job();
      end
    end
    steady_sender = 1'b0;
  endtask

  // Test sequence.
  initial begin
    int drain_wait;
    drain_wait = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_pops();
    test_extremes_and_ties();
    test_fill_and_overflow();
    test_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && drain_wait < 2000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d result beats never arrived", $time, pending_results.size());
    end
    $display("Sent %0d beats: %0d adds, %0d pops, %0d empty pops, %0d refused adds.",
             items_sent, added_seen, popped_seen, empty_seen, full_seen);
    $display("Covered extreme priorities, ties, a full queue and a long output stall.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 300000);
    $display("Run timed out with %0d result beats pending.", pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
